@@ design/cdq_pkg.sv @@
// shared types and constants of the circular deque
package cdq_pkg;

  // default sizes
  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned CapResetDef  = 16;

  // field widths fixed by the interface
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned OccW    = 5;
  localparam int unsigned CfgW    = 5;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  // status codes
  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_e;

endpackage

@@ design/cdq_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/circular_deque_top.sv @@
// circular deque: ring buffer in ram with cached front and rear values
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-----------------------------------
//  in      | input     | in_valid_i / in_stall_o      | op_i, data_i
//  out     | output    | out_valid_o / out_stall_i    | status_o, front_value_o,
//          |           |                              | rear_value_o, empty_flag_o,
//          |           |                              | full_flag_o, occupancy_o
//  cfg     | input     | cfg_we_i                     | cfg_wdata_i (capacity)
//
// an item is taken in ST_IDLE, which updates pointers, count and ram; input
// stalls in ST_RESP, which collects the ram read of the new front or rear
// entry after a pop, as the single ram read port has a registered read.
// reset clears pointers and count and sets capacity; the ram is not cleared.
// a stalled result waits in the output register; the next item is taken
// once the result has moved into it.
module circular_deque_top
  #(
  parameter int unsigned DEPTH      = cdq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DataWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [cdq_pkg::CfgW-1:0]    cfg_wdata_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cdq_pkg::OpW-1:0]     op_i,
  input  logic signed [cdq_pkg::ValueW-1:0] data_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cdq_pkg::StatusW-1:0] status_o,
  output logic signed [cdq_pkg::ValueW-1:0] front_value_o,
  output logic signed [cdq_pkg::ValueW-1:0] rear_value_o,
  output logic                        empty_flag_o,
  output logic                        full_flag_o,
  output logic [cdq_pkg::OccW-1:0]    occupancy_o
);

  import cdq_pkg::*;

  localparam int unsigned PtrW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CopyW = (DATA_WIDTH < ValueW) ? DATA_WIDTH : ValueW;
  localparam int unsigned CapRst = (CapResetDef > DEPTH) ? DEPTH : CapResetDef;

  // pointer stepping around a ring of cap entries
  function automatic logic [PtrW-1:0] step_up(input logic [PtrW-1:0] idx,
                                              input logic [CntW-1:0] cap);
    logic [CntW-1:0] nxt;
    nxt = CntW'(idx) + CntW'(1);
    return (nxt >= cap) ? '0 : PtrW'(nxt);
  endfunction

  function automatic logic [PtrW-1:0] step_down(input logic [PtrW-1:0] idx,
                                                input logic [CntW-1:0] cap);
    logic [CntW-1:0] lst;
    lst = cap - CntW'(1);
    return (idx == '0) ? PtrW'(lst) : idx - PtrW'(1);
  endfunction

  state_e state_q, state_d;

  logic [CntW-1:0]       cap_q, cap_d;
  logic [PtrW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] front_q, front_d, rear_q, rear_d;
  logic                  upd_front_q, upd_front_d, upd_rear_q, upd_rear_d;
  status_e               stat_q, stat_d;

  logic                  accept;
  logic                  load_out;

  logic                  ram_we, ram_re;
  logic [PtrW-1:0]       ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [DATA_WIDTH-1:0] res_front, res_rear;
  logic [31:0]           cfg_ext;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [ValueW-1:0]     out_front_q, out_rear_q;
  logic                  out_empty_q, out_full_q;
  logic [OccW-1:0]       out_occ_q;

  // ring storage
  cdq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_RESP: load_out = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign accept    = in_valid_i && !in_stall_o;
  assign ram_wdata = DATA_WIDTH'(data_i[CopyW-1:0]);

  // operation decode: pointers, count, ram access and cached end values
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    front_d     = front_q;
    rear_d      = rear_q;
    upd_front_d = 1'b0;
    upd_rear_d  = 1'b0;
    stat_d      = STAT_OK;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_re      = 1'b0;
    ram_raddr   = head_q;
    case (op_e'(op_i))
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (cnt_q >= cap_q) begin
          stat_d = STAT_FULL;
        end else if (cnt_q == '0) begin
          head_d    = '0;
          tail_d    = '0;
          ram_we    = accept;
          ram_waddr = '0;
          front_d   = ram_wdata;
          rear_d    = ram_wdata;
          cnt_d     = CntW'(1);
        end else if (op_e'(op_i) == OP_PUSH_FRONT) begin
          head_d    = step_down(head_q, cap_q);
          ram_we    = accept;
          ram_waddr = head_d;
          front_d   = ram_wdata;
          cnt_d     = cnt_q + CntW'(1);
        end else begin
          tail_d    = step_up(tail_q, cap_q);
          ram_we    = accept;
          ram_waddr = tail_d;
          rear_d    = ram_wdata;
          cnt_d     = cnt_q + CntW'(1);
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (cnt_q == '0) begin
          stat_d = STAT_EMPTY;
        end else if (cnt_q == CntW'(1)) begin
          cnt_d  = '0;
          head_d = '0;
          tail_d = '0;
        end else if (op_e'(op_i) == OP_POP_FRONT) begin
          head_d      = step_up(head_q, cap_q);
          ram_re      = accept;
          ram_raddr   = head_d;
          upd_front_d = 1'b1;
          cnt_d       = cnt_q - CntW'(1);
        end else begin
          tail_d     = step_down(tail_q, cap_q);
          ram_re     = accept;
          ram_raddr  = tail_d;
          upd_rear_d = 1'b1;
          cnt_d      = cnt_q - CntW'(1);
        end
      end
      default: begin
        // query and unused codes leave the state alone
        stat_d = STAT_OK;
      end
    endcase
  end

  // end values after a pop come from the ram read
  assign res_front = upd_front_q ? ram_rdata : front_q;
  assign res_rear  = upd_rear_q  ? ram_rdata : rear_q;

  // capacity write with clamping to 1..DEPTH
  assign cfg_ext = 32'(cfg_wdata_i);
  always_comb begin
    if (cfg_ext == 32'd0) begin
      cap_d = CntW'(1);
    end else if (cfg_ext > 32'(DEPTH)) begin
      cap_d = CntW'(DEPTH);
    end else begin
      cap_d = CntW'(cfg_ext);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CntW'(CapRst);
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      upd_front_q <= 1'b0;
      upd_rear_q  <= 1'b0;
      stat_q      <= STAT_OK;
    end else begin
      state_q <= state_d;
      if (accept) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        cnt_q       <= cnt_d;
        upd_front_q <= upd_front_d;
        upd_rear_q  <= upd_rear_d;
        stat_q      <= stat_d;
      end else if (state_q == ST_RESP) begin
        upd_front_q <= 1'b0;
        upd_rear_q  <= 1'b0;
      end
      // capacity only while empty, when both pointers already sit at zero
      if (cfg_we_i && cnt_q == '0) begin
        cap_q <= cap_d;
      end
    end
  end

  // cached front and rear values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_q <= front_d;
      rear_q  <= rear_d;
    end else if (state_q == ST_RESP) begin
      front_q <= res_front;
      rear_q  <= res_rear;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= stat_q;
      out_front_q  <= (cnt_q == '0) ? '0 : ValueW'(res_front[CopyW-1:0]);
      out_rear_q   <= (cnt_q == '0) ? '0 : ValueW'(res_rear[CopyW-1:0]);
      out_empty_q  <= (cnt_q == '0);
      out_full_q   <= (cnt_q == cap_q);
      out_occ_q    <= OccW'(cnt_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign front_value_o = out_front_q;
  assign rear_value_o  = out_rear_q;
  assign empty_flag_o  = out_empty_q;
  assign full_flag_o   = out_full_q;
  assign occupancy_o   = out_occ_q;

  // count never passes the capacity
  a_cnt_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cap_q)
    else $error("entry count above capacity");

  // an empty deque has both pointers at zero
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("pointers not reset on empty deque");

  // pointers stay inside the ring in use
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (CntW'(head_q) < cap_q && CntW'(tail_q) < cap_q))
    else $error("pointer outside capacity");

  // an accepted push with room grows the count by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_i == OP_PUSH_FRONT || op_i == OP_PUSH_REAR) && cnt_q < cap_q)
    |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("push did not grow the count");

  // ram is never read and written in the same cycle
  a_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ram read and write overlap");

endmodule
